FILE: src/fgre_pkg.sv
`timescale 1ns / 1ps

package fgre_pkg;

	// Character range covered by the font
	localparam int unsigned GLYPH_FIRST   = 32;
	localparam int unsigned GLYPH_LAST    = 90;
	localparam int unsigned GLYPH_COLS    = 5;
	localparam int unsigned GLYPH_ROWS    = 7;
	localparam int unsigned GLYPH_ADVANCE = 6;
	localparam int unsigned GLYPH_COUNT   = GLYPH_LAST - GLYPH_FIRST + 1;
	localparam int unsigned ROM_DEPTH     = GLYPH_COUNT * GLYPH_COLS;

	localparam int unsigned IDX_W = $clog2(GLYPH_COUNT);
	localparam int unsigned COL_W = $clog2(GLYPH_COLS);
	localparam int unsigned ROW_W = $clog2(GLYPH_ROWS);
	localparam int unsigned ROM_W = $clog2(ROM_DEPTH);

	// Default depth of the queue between front and back
	localparam int unsigned FGRE_QUEUE_DEPTH = 2;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_FG_COLOR = 2'd0,
		REG_BG_COLOR = 2'd1,
		REG_SCALE    = 2'd2
	} fgre_reg_t;

	typedef struct packed {
		logic [7:0]  char_code;
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic        string_start;
	} fgre_in_t;

	typedef struct packed {
		logic [7:0]  win_col_start;
		logic [7:0]  win_col_end;
		logic [7:0]  win_row_start;
		logic [7:0]  win_row_end;
		logic [15:0] fill_color;
		logic        last_rect;
	} fgre_out_t;

	// One drawable character waiting for the back end
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [7:0]       x;
		logic [7:0]       y;
	} fgre_job_t;

	// Back end status seen by the top level
	typedef struct packed {
		logic busy;
		logic at_last;
	} fgre_back_stat_t;

	// Font columns, bit 0 at the top
	localparam logic [7:0] GLYPH_ROM [ROM_DEPTH] = '{
		8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
		8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
		8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
		8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00,
		8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,
		8'h08,8'h2A,8'h1C,8'h2A,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
		8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
		8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
		8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
		8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31,
		8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
		8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
		8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
		8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,
		8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14,
		8'h41,8'h22,8'h14,8'h08,8'h00, 8'h02,8'h01,8'h51,8'h09,8'h06,
		8'h32,8'h49,8'h79,8'h41,8'h3E, 8'h7E,8'h11,8'h11,8'h11,8'h7E,
		8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
		8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41,
		8'h7F,8'h09,8'h09,8'h01,8'h01, 8'h3E,8'h41,8'h41,8'h51,8'h32,
		8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
		8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41,
		8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h04,8'h02,8'h7F,
		8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
		8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E,
		8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h46,8'h49,8'h49,8'h49,8'h31,
		8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
		8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h7F,8'h20,8'h18,8'h20,8'h7F,
		8'h63,8'h14,8'h08,8'h14,8'h63, 8'h03,8'h04,8'h78,8'h04,8'h03,
		8'h61,8'h51,8'h49,8'h45,8'h43
	};

	// Look up one font column: address = idx * 5 + col
	function automatic logic [7:0] glyph_byte(input logic [IDX_W-1:0] idx,
			input logic [COL_W-1:0] col);
		logic [ROM_W-1:0] addr;
		addr = ROM_W'(idx) * ROM_W'(GLYPH_COLS) + ROM_W'(col);
		return GLYPH_ROM[addr];
	endfunction

endpackage

FILE: src/fgre_front.sv
`timescale 1ns / 1ps

module fgre_front import fgre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_stall,
	input  fgre_in_t  char_data,
	input  logic [7:0] scale,
	output logic      push_valid,
	input  logic      push_ready,
	output fgre_job_t push_data
);

	logic [15:0] cursor_x_q;
	logic [15:0] cursor_y_q;
	logic [15:0] cur_x;
	logic [15:0] cur_y;
	logic [10:0] advance;
	logic        accept;
	logic        drawable;

	// Hold requests while the queue has no room
	assign char_stall = !push_ready;
	assign accept     = char_valid && !char_stall;

	// Pick the cursor for this character and classify the code
	always_comb begin
		cur_x    = char_data.string_start ? char_data.start_x : cursor_x_q;
		cur_y    = char_data.string_start ? char_data.start_y : cursor_y_q;
		drawable = (char_data.char_code >= 8'(GLYPH_FIRST)) &&
			(char_data.char_code <= 8'(GLYPH_LAST));
		advance  = ({3'b000, scale} << 2) + ({3'b000, scale} << 1);
	end

	// Queue only drawable characters
	assign push_valid     = accept && drawable;
	assign push_data.idx  = IDX_W'(char_data.char_code - 8'(GLYPH_FIRST));
	assign push_data.x    = cur_x[7:0];
	assign push_data.y    = cur_y[7:0];

	// Advance the cursor after every accepted character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (accept) begin
			cursor_x_q <= cur_x + 16'(advance);
			cursor_y_q <= cur_y;
		end
	end

endmodule

FILE: src/fgre_queue.sv
`timescale 1ns / 1ps

module fgre_queue import fgre_pkg::*; #(
	parameter int unsigned DEPTH = FGRE_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  fgre_job_t push_data,
	output logic      pop_valid,
	input  logic      pop_ready,
	output fgre_job_t pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	fgre_job_t         slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store an entry at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/fgre_back.sv
`timescale 1ns / 1ps

module fgre_back import fgre_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     fg_color,
	input  logic [15:0]     bg_color,
	input  logic [7:0]      scale,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  fgre_job_t       pop_data,
	output logic            rect_valid,
	input  logic            rect_stall,
	output fgre_out_t       rect_data,
	output fgre_back_stat_t stat
);

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [7:0]       px_q;
	logic [7:0]       py_q;
	logic [7:0]       y0_q;
	logic             out_valid_q;
	fgre_out_t        out_q;
	fgre_out_t        rect;
	logic [7:0]       bits;
	logic             at_last;
	logic             step;
	logic             load;

	// Build the square for the current column and row
	always_comb begin
		bits               = glyph_byte(idx_q, col_q);
		at_last            = (col_q == COL_W'(GLYPH_COLS - 1)) &&
			(row_q == ROW_W'(GLYPH_ROWS - 1));
		rect.win_col_start = px_q;
		rect.win_col_end   = px_q + scale - 8'd1;
		rect.win_row_start = py_q;
		rect.win_row_end   = py_q + scale - 8'd1;
		rect.fill_color    = bits[row_q] ? fg_color : bg_color;
		rect.last_rect     = at_last;
	end

	// Step when the output register is free or being drained
	assign step      = busy_q && (!out_valid_q || !rect_stall);
	assign load      = pop_valid && (!busy_q || (step && at_last));
	assign pop_ready = !busy_q || (step && at_last);

	// Walk columns, then rows within each column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			col_q  <= '0;
			row_q  <= '0;
		end else if (step) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end
			if (row_q == ROW_W'(GLYPH_ROWS - 1)) begin
				row_q <= '0;
				col_q <= col_q + 1'b1;
			end else begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	// Track window origins
	always_ff @(posedge clk) begin
		if (load) begin
			idx_q <= pop_data.idx;
			px_q  <= pop_data.x;
			py_q  <= pop_data.y;
			y0_q  <= pop_data.y;
		end else if (step) begin
			if (row_q == ROW_W'(GLYPH_ROWS - 1)) begin
				px_q <= px_q + scale;
				py_q <= y0_q;
			end else begin
				py_q <= py_q + scale;
			end
		end
	end

	// Hold the square until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!rect_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= rect;
		end
	end

	assign rect_valid   = out_valid_q;
	assign rect_data    = out_q;
	assign stat.busy    = busy_q;
	assign stat.at_last = at_last;

endmodule

FILE: src/font_glyph_rect_expander.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// char      in         char_valid/char_stall  char_data  (fgre_in_t)
// rect      out        rect_valid/rect_stall  rect_data  (fgre_out_t)
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// The back end emits one square per cycle while rect is not stalled, from a single
// rectangle unit, in column-then-row order.
// A rejected code is accepted by the front end and never reaches the queue.
// The queue lets the front accept further characters while the back is drawing.
// Asynchronous reset clears the cursor, queue, back end and output valid, and
// loads the register defaults. A stall on rect holds the back end in place.

module font_glyph_rect_expander import fgre_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = FGRE_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  fgre_in_t    char_data,
	output logic        rect_valid,
	input  logic        rect_stall,
	output fgre_out_t   rect_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0]     fg_color_q;
	logic [15:0]     bg_color_q;
	logic [7:0]      scale_q;
	logic            push_valid;
	logic            push_ready;
	fgre_job_t       push_data;
	logic            pop_valid;
	logic            pop_ready;
	fgre_job_t       pop_data;
	fgre_back_stat_t bk_stat;

	// Take register writes at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color_q <= 16'hFFFF;
			bg_color_q <= 16'h0000;
			scale_q    <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FG_COLOR: fg_color_q <= cfg_data;
				REG_BG_COLOR: bg_color_q <= cfg_data;
				REG_SCALE:    scale_q    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	fgre_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.scale      (scale_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	fgre_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	fgre_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fg_color   (fg_color_q),
		.bg_color   (bg_color_q),
		.scale      (scale_q),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.rect_valid (rect_valid),
		.rect_stall (rect_stall),
		.rect_data  (rect_data),
		.stat       (bk_stat)
	);

`ifndef SYNTHESIS
	// A queued character is visible to the back end on the next cycle
	a_push_seen: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && push_ready |=> pop_valid)
		else $error("queued character lost");

	// New output only comes from an active back end
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rect_valid) |-> $past(bk_stat.busy))
		else $error("square emitted while back end idle");

	// The final square of a character is flagged as last
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.busy && bk_stat.at_last && !rect_stall |=>
			rect_valid && rect_data.last_rect)
		else $error("last square not flagged");
`endif

endmodule

FILE: sim/rect_stream_checker.sv
`timescale 1ns / 1ps

module rect_stream_checker import fgre_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	input  logic        char_stall,
	input  fgre_in_t    char_data,
	input  logic        rect_valid,
	input  logic        rect_stall,
	input  fgre_out_t   rect_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatch_count,
	output int          rects_pending
);

	localparam int unsigned CODE_FIRST     = 32;
	localparam int unsigned CODE_LAST      = 90;
	localparam int unsigned FONT_COLS      = 5;
	localparam int unsigned FONT_ROWS      = 7;
	localparam int unsigned CURSOR_STEP    = 6;
	localparam int unsigned RECTS_PER_CHAR = FONT_COLS * FONT_ROWS;
	localparam int unsigned FONT_BYTES     = (CODE_LAST - CODE_FIRST + 1) * FONT_COLS;
	localparam int unsigned FONT_AW        = $clog2(FONT_BYTES);

	// 5x7 font, one byte per column, bit 0 is the top row
	localparam logic [7:0] FONT [FONT_BYTES] = '{
		8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
		8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
		8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
		8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00,
		8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,
		8'h08,8'h2A,8'h1C,8'h2A,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
		8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
		8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
		8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
		8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31,
		8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
		8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
		8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
		8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,
		8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14,
		8'h41,8'h22,8'h14,8'h08,8'h00, 8'h02,8'h01,8'h51,8'h09,8'h06,
		8'h32,8'h49,8'h79,8'h41,8'h3E, 8'h7E,8'h11,8'h11,8'h11,8'h7E,
		8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
		8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41,
		8'h7F,8'h09,8'h09,8'h01,8'h01, 8'h3E,8'h41,8'h41,8'h51,8'h32,
		8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
		8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41,
		8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h04,8'h02,8'h7F,
		8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
		8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E,
		8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h46,8'h49,8'h49,8'h49,8'h31,
		8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
		8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h7F,8'h20,8'h18,8'h20,8'h7F,
		8'h63,8'h14,8'h08,8'h14,8'h63, 8'h03,8'h04,8'h78,8'h04,8'h03,
		8'h61,8'h51,8'h49,8'h45,8'h43
	};

	logic [15:0] fg;
	logic [15:0] bg;
	logic [7:0]  px_scale;
	logic [15:0] cur_x;
	logic [15:0] cur_y;
	fgre_out_t   expected_rects [$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns: rect mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want)
			report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
	endtask

	// Expand one accepted character into its fill squares and move the cursor
	task automatic expand_glyph(input fgre_in_t c);
		int unsigned base;
		logic [7:0]  bits;
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] px_end;
		logic [15:0] py_end;
		fgre_out_t   r;
		if (c.string_start) begin
			cur_x = c.start_x;
			cur_y = c.start_y;
		end
		if (c.char_code >= 8'(CODE_FIRST) && c.char_code <= 8'(CODE_LAST)) begin
			base = (c.char_code - CODE_FIRST) * FONT_COLS;
			for (int col = 0; col < FONT_COLS; col++) begin
				bits = FONT[FONT_AW'(base + col)];
				px = cur_x + 16'(col * px_scale);
				px_end = px + 16'(px_scale) - 16'd1;
				for (int row = 0; row < FONT_ROWS; row++) begin
					py = cur_y + 16'(row * px_scale);
					py_end = py + 16'(px_scale) - 16'd1;
					r.win_col_start = px[7:0];
					r.win_col_end   = px_end[7:0];
					r.win_row_start = py[7:0];
					r.win_row_end   = py_end[7:0];
					r.fill_color    = bits[3'(row)] ? fg : bg;
					r.last_rect     = (col * FONT_ROWS + row == RECTS_PER_CHAR - 1);
					expected_rects.push_back(r);
				end
			end
		end
		cur_x = cur_x + 16'(CURSOR_STEP * px_scale);
	endtask

	// Compare one accepted square with the oldest expected one
	task automatic check_rect(input fgre_out_t got);
		fgre_out_t want;
		if (expected_rects.size() == 0) begin
			report_mismatch($sformatf("unexpected square %p", got));
		end else begin
			want = expected_rects.pop_front();
			compare_field("win_col_start", 16'(want.win_col_start),
				16'(got.win_col_start));
			compare_field("win_col_end", 16'(want.win_col_end), 16'(got.win_col_end));
			compare_field("win_row_start", 16'(want.win_row_start),
				16'(got.win_row_start));
			compare_field("win_row_end", 16'(want.win_row_end), 16'(got.win_row_end));
			compare_field("fill_color", want.fill_color, got.fill_color);
			compare_field("last_rect", 16'(want.last_rect), 16'(got.last_rect));
		end
	endtask

	// Track register writes, character requests and squares
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg = 16'hFFFF;
			bg = 16'h0000;
			px_scale = 8'd1;
			cur_x = 16'd0;
			cur_y = 16'd0;
			mismatch_count = 0;
			expected_rects.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FG_COLOR: fg = cfg_data;
					REG_BG_COLOR: bg = cfg_data;
					REG_SCALE:    px_scale = cfg_data[7:0];
					default:      ;
				endcase
			end
			if (char_valid && !char_stall)
				expand_glyph(char_data);
			if (rect_valid && !rect_stall)
				check_rect(rect_data);
		end
		rects_pending = expected_rects.size();
	end

endmodule

FILE: sim/font_glyph_rect_expander_test.sv
`timescale 1ns / 1ps

module font_glyph_rect_expander_test;

	import fgre_pkg::*;

	// Index with no register behind it
	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 50;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_stall;
	fgre_in_t    char_data = '0;
	logic        rect_valid;
	logic        rect_stall = 1'b0;
	fgre_out_t   rect_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	bit idling = 1'b1;
	int gap_free_items = 0;
	int stall_left = 0;
	int calm_cycles = 0;
	int idle_cycles = 0;
	int mismatch_count;
	int rects_pending;

	always #10 clk = ~clk;

	font_glyph_rect_expander dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.rect_valid (rect_valid),
		.rect_stall (rect_stall),
		.rect_data  (rect_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	rect_stream_checker rect_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_valid     (char_valid),
		.char_stall     (char_stall),
		.char_data      (char_data),
		.rect_valid     (rect_valid),
		.rect_stall     (rect_stall),
		.rect_data      (rect_data),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.rects_pending  (rects_pending)
	);

	// While idling is set, stall the square stream in bursts, with calm stretches between
	always @(negedge clk) begin
		logic stall_next;
		stall_next = 1'b0;
		if (idling) begin
			if (stall_left > 0) begin
				stall_next = 1'b1;
				stall_left--;
			end else if (calm_cycles > 0) begin
				calm_cycles--;
			end else begin
				case ($urandom_range(0, 19))
					0:       calm_cycles = $urandom_range(20, 150);
					1, 2, 3: begin
						stall_next = 1'b1;
						stall_left = $urandom_range(1, 8) - 1;
					end
					default: ;
				endcase
			end
		end
		rect_stall <= stall_next;
	end

	// Abort when no channel moves for too long
	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (rect_valid && !rect_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("font_glyph_rect_expander_test: FAIL");
			$finish;
		end
	end

	// Drive one character request and hold it until accepted
	task automatic send_char(input logic [7:0] code, input logic [15:0] x,
			input logic [15:0] y, input logic start);
		int gap;
		@(negedge clk);
		gap = 0;
		if (idling) begin
			if (gap_free_items > 0)
				gap_free_items--;
			else if ($urandom_range(0, 9) == 0)
				gap_free_items = $urandom_range(5, 25);
			else if ($urandom_range(0, 2) == 0)
				gap = $urandom_range(1, 8);
		end
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_valid <= 1'b1;
		char_data <= '{char_code: code, start_x: x, start_y: y, string_start: start};
		@(posedge clk);
		while (char_stall) @(posedge clk);
	endtask

	// Drop the request line and wait until every square is out
	task automatic drain();
		@(negedge clk);
		char_valid <= 1'b0;
		while (rects_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly drawable codes, now and then any byte
	function automatic logic [7:0] pick_code();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom);
		return 8'($urandom_range(32, 90));
	endfunction

	task automatic random_config();
		logic [7:0] s;
		case ($urandom_range(0, 9))
			0:       s = 8'd255;
			1:       s = 8'd0;
			2, 3:    s = 8'd1;
			4, 5:    s = 8'd2;
			default: s = 8'($urandom_range(1, 255));
		endcase
		write_reg(REG_FG_COLOR, 16'($urandom));
		write_reg(REG_BG_COLOR, 16'($urandom));
		write_reg(REG_SCALE, {8'($urandom), s});
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_NONE, 16'($urandom));
	endtask

	// One string: usually a start item, then characters that mostly follow the cursor
	task automatic random_string(output int count);
		count = $urandom_range(1, 10);
		send_char(pick_code(), 16'($urandom), 16'($urandom),
			$urandom_range(0, 9) != 0);
		repeat (count - 1)
			send_char(pick_code(), 16'($urandom), 16'($urandom),
				$urandom_range(0, 15) == 0);
	endtask

	initial begin
		int items_sent;
		int n;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Reset colors and scale: edges of the code range, cursor wrap
		send_char(8'd65, 16'h0000, 16'h0000, 1'b1);
		send_char(8'd32, 16'h0000, 16'h0000, 1'b0);
		send_char(8'd90, 16'h0000, 16'h0000, 1'b0);
		send_char(8'd31, 16'h0000, 16'h0000, 1'b0);
		send_char(8'd91, 16'h0000, 16'h0000, 1'b0);
		send_char(8'd0, 16'h0000, 16'h0000, 1'b0);
		send_char(8'd255, 16'h1234, 16'h0040, 1'b1);
		send_char(8'd33, 16'hFFFF, 16'hFFFF, 1'b0);
		send_char(8'd56, 16'hFFFF, 16'hFFFF, 1'b1);
		send_char(8'd87, 16'h00FC, 16'h00FB, 1'b1);
		send_char(8'd64, 16'h0000, 16'h0000, 1'b0);
		drain();

		// Largest scale, swapped colors, write to the unused index
		write_reg(REG_FG_COLOR, 16'h0000);
		write_reg(REG_BG_COLOR, 16'hFFFF);
		write_reg(REG_SCALE, 16'hFFFF);
		write_reg(REG_NONE, 16'hFFFF);
		send_char(8'd77, 16'hFF00, 16'h0000, 1'b1);
		send_char(8'd35, 16'h0000, 16'h0000, 1'b0);
		send_char(8'd127, 16'h0000, 16'h0000, 1'b0);
		send_char(8'd81, 16'hFFFF, 16'hFFFF, 1'b1);
		drain();

		// Zero scale: the cursor stays put
		write_reg(REG_SCALE, 16'h0100);
		write_reg(REG_FG_COLOR, 16'hF800);
		write_reg(REG_BG_COLOR, 16'h07E0);
		send_char(8'd66, 16'h0010, 16'h0020, 1'b1);
		send_char(8'd88, 16'h0000, 16'h0000, 1'b0);
		send_char(8'd200, 16'h0000, 16'h0000, 1'b0);
		send_char(8'd90, 16'h0000, 16'h0000, 1'b0);
		drain();

		// Small scale with junk in the upper data byte
		write_reg(REG_SCALE, 16'hA503);
		write_reg(REG_FG_COLOR, 16'hAAAA);
		write_reg(REG_BG_COLOR, 16'h5555);
		send_char(8'd48, 16'h00F0, 16'h0010, 1'b1);
		send_char(8'd63, 16'h0000, 16'h0000, 1'b0);
		send_char(8'd75, 16'h0000, 16'h0000, 1'b0);
		send_char(8'd32, 16'h8000, 16'h7FFF, 1'b1);

		// Random strings under random settings, no idling in the last phase
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			if (phase == PHASES - 1)
				idling = 1'b0;
			random_config();
			items_sent = 0;
			while (items_sent < PHASE_ITEMS) begin
				random_string(n);
				items_sent += n;
			end
		end

		drain();
		if (mismatch_count == 0)
			$display("font_glyph_rect_expander_test: PASS");
		else
			$display("font_glyph_rect_expander_test: FAIL");
		$finish;
	end

endmodule
